>>> rtl/mprvc_pkg.sv
// Shared types, register codes and velocity curve tables for the MIDI pad router.
package mprvc_pkg;

   localparam int PAD_SLOTS   = 16;
   localparam int PAD_IDX_W   = 4;
   localparam int KIND_W      = 2;
   localparam int CHAN_W      = 5;
   localparam int NOTE_W      = 7;
   localparam int VEL_W       = 7;
   localparam int POS_W       = 16;
   localparam int CURVE_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 56;
   localparam int NOTES_W     = 56;
   localparam int CHANS_W     = 40;
   localparam int CURVES_W    = 48;
   localparam int CODES_W     = 56;
   localparam int VEL_DEPTH   = 1 << VEL_W;

   // highest channel number a filter can name; larger filters saturate here
   localparam logic [CHAN_W-1:0] CHAN_MAX = 5'd16;
   localparam logic [VEL_W-1:0]  VEL_MIN  = 7'd1;

   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd2;

   localparam logic [CURVE_W-1:0] CURVE_LINEAR = 3'd0;
   localparam logic [CURVE_W-1:0] CURVE_LOG    = 3'd1;
   localparam logic [CURVE_W-1:0] CURVE_EXP    = 3'd2;
   localparam logic [CURVE_W-1:0] CURVE_SCURVE = 3'd3;
   localparam logic [CURVE_W-1:0] CURVE_FIXED  = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_NOTES_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NOTES_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANS_LOW  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANS_HIGH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CURVES     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CODES_LOW  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CODES_HIGH = 3'd6;

   // default drum map: 36,38,42,46,41,43,45,49 / 51,57,39,37,56,47,50,48
   localparam logic [NOTES_W-1:0] NOTES_LOW_RESET  = 56'd27783948382409508;
   localparam logic [NOTES_W-1:0] NOTES_HIGH_RESET = 56'd27243130108107955;

   typedef struct packed {
      logic [KIND_W-1:0] message_kind;
      logic [CHAN_W-1:0] channel;
      logic [NOTE_W-1:0] note_number;
      logic [VEL_W-1:0]  velocity;
      logic [POS_W-1:0]  sample_position;
   } req_payload_type;

   typedef struct packed {
      logic [PAD_IDX_W-1:0] pad_slot;
      logic [NOTE_W-1:0]    pad_note;
      logic                 is_note_on;
      logic [VEL_W-1:0]     out_velocity;
      logic [POS_W-1:0]     event_position;
      logic                 last_of_run;
   } rsp_payload_type;

   typedef logic [VEL_DEPTH-1:0][VEL_W-1:0] vel_table_type;

   // Elaboration-time table builder; results already clamped to 1..127.
   function automatic vel_table_type build_curve(input logic [CURVE_W-1:0] curve);
      vel_table_type t;
      int unsigned   m;
      int unsigned   n;
      int unsigned   x;
      for (int unsigned v = 0; v < VEL_DEPTH; v++) begin
         case (curve)
            CURVE_LOG: begin
               x = 127 * v;
               n = 0;
               while ((n + 1) * (n + 1) <= x) n++;
               m = (x > n * n + n) ? n + 1 : n;
            end
            CURVE_EXP:    m = (2 * v * v + 127) / 254;
            CURVE_SCURVE: m = (2 * v * v * (381 - 2 * v) + 16129) / 32258;
            default:      m = v;
         endcase
         if (m < 1) m = 1;
         if (m > 127) m = 127;
         t[v] = VEL_W'(m);
      end
      return t;
   endfunction

   localparam vel_table_type LOG_TABLE    = build_curve(CURVE_LOG);
   localparam vel_table_type EXP_TABLE    = build_curve(CURVE_EXP);
   localparam vel_table_type SCURVE_TABLE = build_curve(CURVE_SCURVE);

endpackage

>>> rtl/midi_pad_router_velocity_curve.sv
// MIDI pad router: pad match, fan-out of routed events and velocity curve mapping.
//
// Usage:
//   req_*  carries one MIDI event per transaction (valid/stall). Note-on and note-off
//          events are matched against every pad's note and channel filter; other
//          events are dropped.
//   rsp_*  carries one routed event per transaction, pads in ascending order, with
//          last_of_run set on the final routed event of each input event.
//   csr_*  writes one of the seven pad registers; always ready. Write only while idle.
// Stages: four register stages (input, match/table lookup, fan-out, output).
// Throughput: one routed event per cycle while rsp_stall is low. An event matching n
//   pads holds the fan-out stage until all n are emitted; an event matching no pad
//   skips it and emits nothing. Back-to-back input is taken whenever fan-out keeps up.
// Reset: synchronous; clears all stage valid bits and loads the default drum map,
//   channel filters "any", linear curves and zero fixed codes.
// Stall: rsp_stall holds the output register; the stall backs up stage by stage and
//   reaches req_stall only once the input, match and fan-out stages all hold events.
module midi_pad_router_velocity_curve #(
   parameter int PAD_COUNT = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mprvc_pkg::req_payload_type            req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mprvc_pkg::rsp_payload_type            rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mprvc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mprvc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int VW = mprvc_pkg::VEL_W;

   // configuration registers
   logic [mprvc_pkg::NOTES_W-1:0]  notes_low_ff, notes_high_ff;
   logic [mprvc_pkg::CHANS_W-1:0]  chans_low_ff, chans_high_ff;
   logic [mprvc_pkg::CURVES_W-1:0] curves_ff;
   logic [mprvc_pkg::CODES_W-1:0]  codes_low_ff, codes_high_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         notes_low_ff  <= mprvc_pkg::NOTES_LOW_RESET;
         notes_high_ff <= mprvc_pkg::NOTES_HIGH_RESET;
         chans_low_ff  <= '0;
         chans_high_ff <= '0;
         curves_ff     <= '0;
         codes_low_ff  <= '0;
         codes_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mprvc_pkg::REG_NOTES_LOW:  notes_low_ff  <= csr_data[mprvc_pkg::NOTES_W-1:0];
            mprvc_pkg::REG_NOTES_HIGH: notes_high_ff <= csr_data[mprvc_pkg::NOTES_W-1:0];
            mprvc_pkg::REG_CHANS_LOW:  chans_low_ff  <= csr_data[mprvc_pkg::CHANS_W-1:0];
            mprvc_pkg::REG_CHANS_HIGH: chans_high_ff <= csr_data[mprvc_pkg::CHANS_W-1:0];
            mprvc_pkg::REG_CURVES:     curves_ff     <= csr_data[mprvc_pkg::CURVES_W-1:0];
            mprvc_pkg::REG_CODES_LOW:  codes_low_ff  <= csr_data[mprvc_pkg::CODES_W-1:0];
            mprvc_pkg::REG_CODES_HIGH: codes_high_ff <= csr_data[mprvc_pkg::CODES_W-1:0];
            default: ;
         endcase
      end
   end

   // per-pad views of the configuration
   logic [2*mprvc_pkg::NOTES_W-1:0] notes_all;
   logic [2*mprvc_pkg::CHANS_W-1:0] chans_all;
   logic [2*mprvc_pkg::CODES_W-1:0] codes_all;
   logic [mprvc_pkg::NOTE_W-1:0]    pad_note  [PAD_COUNT];
   logic [mprvc_pkg::CHAN_W-1:0]    pad_chan  [PAD_COUNT];
   logic [mprvc_pkg::CURVE_W-1:0]   pad_curve [PAD_COUNT];
   logic [VW-1:0]                   pad_code  [PAD_COUNT];

   assign notes_all = {notes_high_ff, notes_low_ff};
   assign chans_all = {chans_high_ff, chans_low_ff};
   assign codes_all = {codes_high_ff, codes_low_ff};

   always_comb begin
      for (int p = 0; p < PAD_COUNT; p++) begin
         pad_note[p]  = notes_all[mprvc_pkg::NOTE_W*p +: mprvc_pkg::NOTE_W];
         pad_chan[p]  = chans_all[mprvc_pkg::CHAN_W*p +: mprvc_pkg::CHAN_W];
         pad_curve[p] = curves_ff[mprvc_pkg::CURVE_W*p +: mprvc_pkg::CURVE_W];
         pad_code[p]  = codes_all[VW*p +: VW];
      end
   end

   // pipeline registers
   logic                        s1_valid_ff, s1_valid_in;
   mprvc_pkg::req_payload_type  s1_event_ff, s1_event_in;

   logic                        s2_valid_ff, s2_valid_in;
   mprvc_pkg::req_payload_type  s2_event_ff, s2_event_in;
   logic [PAD_COUNT-1:0]        s2_mask_ff, s2_mask_in;
   logic                        s2_on_ff, s2_on_in;
   logic [VW-1:0]               s2_log_ff, s2_log_in;
   logic [VW-1:0]               s2_exp_ff, s2_exp_in;
   logic [VW-1:0]               s2_scurve_ff, s2_scurve_in;

   logic                        s3_valid_ff, s3_valid_in;
   mprvc_pkg::req_payload_type  s3_event_ff, s3_event_in;
   logic [PAD_COUNT-1:0]        s3_mask_ff, s3_mask_in;
   logic                        s3_on_ff, s3_on_in;
   logic [VW-1:0]               s3_log_ff, s3_log_in;
   logic [VW-1:0]               s3_exp_ff, s3_exp_in;
   logic [VW-1:0]               s3_scurve_ff, s3_scurve_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   mprvc_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   // flow control, from the output back to the input
   logic                        out_free, s3_emit, s3_last, s3_free;
   logic                        s2_adv, s2_free, s1_free;
   logic [PAD_COUNT-1:0]        s3_pick, s3_rest;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s3_pick   = s3_mask_ff & (~s3_mask_ff + PAD_COUNT'(1));
   assign s3_rest   = s3_mask_ff & ~s3_pick;
   assign s3_last   = (s3_rest == '0);
   assign s3_emit   = s3_valid_ff && out_free;
   assign s3_free   = !s3_valid_ff || (s3_emit && s3_last);
   // events with no matching pad slip past a busy fan-out stage
   assign s2_adv    = s2_valid_ff && (s3_free || (s2_mask_ff == '0));
   assign s2_free   = !s2_valid_ff || s2_adv;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;

   // stage 1: input register
   always_comb begin
      if (s1_free) begin
         s1_valid_in = req_valid;
         s1_event_in = req_payload;
      end else begin
         s1_valid_in = s1_valid_ff;
         s1_event_in = s1_event_ff;
      end
   end

   // stage 2: pad match and curve table lookups
   logic                         s1_is_note;
   logic [PAD_COUNT-1:0]         s1_match;
   logic [mprvc_pkg::CHAN_W-1:0] chan_eff;

   always_comb begin
      s1_is_note = (s1_event_ff.message_kind == mprvc_pkg::KIND_NOTE_OFF)
                || (s1_event_ff.message_kind == mprvc_pkg::KIND_NOTE_ON);
      chan_eff = '0;
      for (int p = 0; p < PAD_COUNT; p++) begin
         chan_eff = (pad_chan[p] > mprvc_pkg::CHAN_MAX) ? mprvc_pkg::CHAN_MAX : pad_chan[p];
         s1_match[p] = s1_is_note && (pad_note[p] == s1_event_ff.note_number)
                    && ((chan_eff == '0) || (chan_eff == s1_event_ff.channel));
      end
   end

   always_comb begin
      if (s2_free) begin
         s2_valid_in  = s1_valid_ff;
         s2_event_in  = s1_event_ff;
         s2_mask_in   = s1_match;
         // a note-on at velocity zero is a note-off
         s2_on_in     = (s1_event_ff.message_kind == mprvc_pkg::KIND_NOTE_ON)
                     && (s1_event_ff.velocity != '0);
         s2_log_in    = mprvc_pkg::LOG_TABLE[s1_event_ff.velocity];
         s2_exp_in    = mprvc_pkg::EXP_TABLE[s1_event_ff.velocity];
         s2_scurve_in = mprvc_pkg::SCURVE_TABLE[s1_event_ff.velocity];
      end else begin
         s2_valid_in  = s2_valid_ff;
         s2_event_in  = s2_event_ff;
         s2_mask_in   = s2_mask_ff;
         s2_on_in     = s2_on_ff;
         s2_log_in    = s2_log_ff;
         s2_exp_in    = s2_exp_ff;
         s2_scurve_in = s2_scurve_ff;
      end
   end

   // stage 3: fan-out, one matching pad per cycle while the output is free, lowest first
   always_comb begin
      if (s3_free) begin
         s3_valid_in  = s2_valid_ff && (s2_mask_ff != '0);
         s3_event_in  = s2_event_ff;
         s3_mask_in   = s2_mask_ff;
         s3_on_in     = s2_on_ff;
         s3_log_in    = s2_log_ff;
         s3_exp_in    = s2_exp_ff;
         s3_scurve_in = s2_scurve_ff;
      end else begin
         s3_valid_in  = s3_valid_ff;
         s3_event_in  = s3_event_ff;
         s3_mask_in   = s3_emit ? s3_rest : s3_mask_ff;
         s3_on_in     = s3_on_ff;
         s3_log_in    = s3_log_ff;
         s3_exp_in    = s3_exp_ff;
         s3_scurve_in = s3_scurve_ff;
      end
   end

   // stage 4: curve select and output register
   logic [mprvc_pkg::PAD_IDX_W-1:0] sel_idx;
   logic [mprvc_pkg::CURVE_W-1:0]   sel_curve;
   logic [VW-1:0]                   sel_code;
   logic [VW-1:0]                   mapped;

   always_comb begin
      sel_idx   = '0;
      sel_curve = '0;
      sel_code  = '0;
      for (int p = 0; p < PAD_COUNT; p++) begin
         if (s3_pick[p]) begin
            sel_idx   = sel_idx | mprvc_pkg::PAD_IDX_W'(p);
            sel_curve = sel_curve | pad_curve[p];
            sel_code  = sel_code | pad_code[p];
         end
      end
      unique case (sel_curve)
         mprvc_pkg::CURVE_LOG:    mapped = s3_log_ff;
         mprvc_pkg::CURVE_EXP:    mapped = s3_exp_ff;
         mprvc_pkg::CURVE_SCURVE: mapped = s3_scurve_ff;
         mprvc_pkg::CURVE_FIXED:  mapped = (sel_code == '0) ? mprvc_pkg::VEL_MIN : sel_code;
         default:                 mapped = s3_event_ff.velocity;
      endcase
   end

   always_comb begin
      if (out_free) begin
         rsp_valid_in                  = s3_valid_ff;
         rsp_payload_in.pad_slot       = sel_idx;
         rsp_payload_in.pad_note       = s3_event_ff.note_number;
         rsp_payload_in.is_note_on     = s3_on_ff;
         rsp_payload_in.out_velocity   = s3_on_ff ? mapped : s3_event_ff.velocity;
         rsp_payload_in.event_position = s3_event_ff.sample_position;
         rsp_payload_in.last_of_run    = s3_last;
      end else begin
         rsp_valid_in   = rsp_valid_ff;
         rsp_payload_in = rsp_payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_event_ff    <= s1_event_in;
      s2_event_ff    <= s2_event_in;
      s2_mask_ff     <= s2_mask_in;
      s2_on_ff       <= s2_on_in;
      s2_log_ff      <= s2_log_in;
      s2_exp_ff      <= s2_exp_in;
      s2_scurve_ff   <= s2_scurve_in;
      s3_event_ff    <= s3_event_in;
      s3_mask_ff     <= s3_mask_in;
      s3_on_ff       <= s3_on_in;
      s3_log_ff      <= s3_log_in;
      s3_exp_ff      <= s3_exp_in;
      s3_scurve_ff   <= s3_scurve_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // the fan-out stage never holds an event without a pad left to emit
   a_s3_mask_live: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_mask_ff != '0))
      else $error("fan-out stage valid with empty pad mask");

   // a non-final emission retires exactly the picked pad and keeps the event
   a_s3_retire: assert property (@(posedge clock) disable iff (reset)
      (s3_emit && !s3_last) |=> (s3_valid_ff && (s3_mask_ff == $past(s3_rest))))
      else $error("fan-out mask did not retire the emitted pad");

   // each emission lands in the output register
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      s3_emit |=> (rsp_valid_ff && (rsp_payload_ff.last_of_run == $past(s3_last))))
      else $error("emitted event missing from output register");

   a_on_velocity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.is_note_on) |-> (rsp_payload_ff.out_velocity != '0))
      else $error("routed note-on with zero velocity");

   a_pad_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_payload_ff.pad_slot) < PAD_COUNT))
      else $error("routed pad index beyond pad count");

endmodule

>>> verif/mprvc_route_checker.sv
// Route checker for the MIDI pad router: shadows the pad registers, predicts and compares.
module mprvc_route_checker
   import mprvc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_payload_type        req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int unsigned            mismatch_count,
   output int unsigned            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [NOTES_W-1:0]  notes_lo;
   logic [NOTES_W-1:0]  notes_hi;
   logic [CHANS_W-1:0]  chans_lo;
   logic [CHANS_W-1:0]  chans_hi;
   logic [CURVES_W-1:0] curve_sel;
   logic [CODES_W-1:0]  codes_lo;
   logic [CODES_W-1:0]  codes_hi;

   rsp_payload_type pending_routes[$];

   function automatic int unsigned round_ratio(input int unsigned num, input int unsigned den);
      int unsigned q;
      q = num / den;
      if (2 * (num % den) > den) q++;
      return q;
   endfunction

   function automatic logic [VEL_W-1:0] shape_velocity(input logic [CURVE_W-1:0] curve,
                                                       input logic [VEL_W-1:0]   code,
                                                       input logic [VEL_W-1:0]   raw);
      int unsigned v;
      int unsigned m;
      v = raw;
      case (curve)
         CURVE_LOG: begin
            // nearest root: smallest m with (2m+1)^2 >= 4*127*v
            m = 0;
            while ((2 * m + 1) * (2 * m + 1) < 4 * 127 * v) m++;
         end
         CURVE_EXP:    m = round_ratio(v * v, 127);
         CURVE_SCURVE: m = round_ratio(v * v * (381 - 2 * v), 16129);
         CURVE_FIXED:  m = code;
         default:      m = v;
      endcase
      if (m < 1) m = 1;
      if (m > 127) m = 127;
      return VEL_W'(m);
   endfunction

   // Fan one MIDI event out to every matching pad; the final hit carries last_of_run.
   function automatic void route_event(input req_payload_type ev);
      rsp_payload_type    held;
      logic               have_held;
      logic               note_on;
      logic [NOTE_W-1:0]  pnote;
      logic [CHAN_W-1:0]  filter;
      logic [CURVE_W-1:0] curve;
      logic [VEL_W-1:0]   code;
      held      = '0;
      have_held = 1'b0;
      if (ev.message_kind != KIND_NOTE_ON && ev.message_kind != KIND_NOTE_OFF) return;
      note_on = (ev.message_kind == KIND_NOTE_ON) && (ev.velocity != '0);
      for (int p = 0; p < PAD_SLOTS; p++) begin
         pnote  = (p < 8) ? notes_lo[(p % 8) * NOTE_W +: NOTE_W]
                          : notes_hi[(p % 8) * NOTE_W +: NOTE_W];
         filter = (p < 8) ? chans_lo[(p % 8) * CHAN_W +: CHAN_W]
                          : chans_hi[(p % 8) * CHAN_W +: CHAN_W];
         code   = (p < 8) ? codes_lo[(p % 8) * VEL_W +: VEL_W]
                          : codes_hi[(p % 8) * VEL_W +: VEL_W];
         curve  = curve_sel[p * CURVE_W +: CURVE_W];
         if (filter > CHAN_MAX) filter = CHAN_MAX;
         if (pnote == ev.note_number && (filter == '0 || filter == ev.channel)) begin
            if (have_held) pending_routes.push_back(held);
            held.pad_slot       = PAD_IDX_W'(p);
            held.pad_note       = pnote;
            held.is_note_on     = note_on;
            held.out_velocity   = note_on ? shape_velocity(curve, code, ev.velocity)
                                          : ev.velocity;
            held.event_position = ev.sample_position;
            held.last_of_run    = 1'b0;
            have_held           = 1'b1;
         end
      end
      if (have_held) begin
         held.last_of_run = 1'b1;
         pending_routes.push_back(held);
      end
   endfunction

   function automatic int unsigned field_diff(input string field, input logic [POS_W-1:0] want,
                                              input logic [POS_W-1:0] got);
      if (want === got) return 0;
      $error("%s: expected %0d, actual %0d", field, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         notes_lo  = NOTES_LOW_RESET;
         notes_hi  = NOTES_HIGH_RESET;
         chans_lo  = '0;
         chans_hi  = '0;
         curve_sel = '0;
         codes_lo  = '0;
         codes_hi  = '0;
         mismatch_count = 0;
         pending_routes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_routes.size() == 0) begin
               $error("routed event with none expected: pad %0d note %0d",
                      rsp_payload.pad_slot, rsp_payload.pad_note);
               mismatch_count++;
            end else begin
               want = pending_routes.pop_front();
               mismatch_count += field_diff("pad_slot", POS_W'(want.pad_slot),
                                            POS_W'(rsp_payload.pad_slot))
                  + field_diff("pad_note", POS_W'(want.pad_note),
                               POS_W'(rsp_payload.pad_note))
                  + field_diff("is_note_on", POS_W'(want.is_note_on),
                               POS_W'(rsp_payload.is_note_on))
                  + field_diff("out_velocity", POS_W'(want.out_velocity),
                               POS_W'(rsp_payload.out_velocity))
                  + field_diff("event_position", want.event_position,
                               rsp_payload.event_position)
                  + field_diff("last_of_run", POS_W'(want.last_of_run),
                               POS_W'(rsp_payload.last_of_run));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_NOTES_LOW:  notes_lo  = csr_data[NOTES_W-1:0];
               REG_NOTES_HIGH: notes_hi  = csr_data[NOTES_W-1:0];
               REG_CHANS_LOW:  chans_lo  = csr_data[CHANS_W-1:0];
               REG_CHANS_HIGH: chans_hi  = csr_data[CHANS_W-1:0];
               REG_CURVES:     curve_sel = csr_data[CURVES_W-1:0];
               REG_CODES_LOW:  codes_lo  = csr_data[CODES_W-1:0];
               REG_CODES_HIGH: codes_hi  = csr_data[CODES_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) route_event(req_payload);
      end
      pending_count = pending_routes.size();
   end

endmodule

>>> verif/tb_top.sv
// Testbench top for the MIDI pad router: clock, reset, stimulus, register setup and verdict.
module tb_top
   import mprvc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0]      KIND_OTHER   = 2'd0;
   localparam logic [KIND_W-1:0]      KIND_SPARE   = 2'd3;
   localparam logic [CURVE_W-1:0]     CURVE_SPARE  = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE    = 3'd7;
   localparam int                     SETTLE_CYCLES = 8;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int unsigned            mismatch_count;
   int unsigned            pending_count;
   logic                   quiet;

   logic [NOTE_W-1:0]  map_note [PAD_SLOTS];
   logic [CHAN_W-1:0]  map_chan [PAD_SLOTS];
   logic [CURVE_W-1:0] map_curve[PAD_SLOTS];
   logic [VEL_W-1:0]   map_code [PAD_SLOTS];
   logic [NOTE_W-1:0]  note_pool[3];

   midi_pad_router_velocity_curve #(.PAD_COUNT(PAD_SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   mprvc_route_checker route_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Output backpressure: clear runs of random length, then stall bursts.
   initial begin : rsp_backpressure
      int unsigned span;
      rsp_stall = 1'b0;
      forever begin
         span = $urandom_range(1, 40);
         repeat (span) begin
            @(negedge clock);
            rsp_stall = 1'b0;
         end
         if (!quiet) begin
            span = $urandom_range(1, 17);
            repeat (span) begin
               @(negedge clock);
               rsp_stall = !quiet;
            end
         end
      end
   end

   function automatic req_payload_type make_event(input logic [KIND_W-1:0] kind,
                                                  input int chan, input int note,
                                                  input int vel, input int pos);
      req_payload_type ev;
      ev.message_kind    = kind;
      ev.channel         = CHAN_W'(chan);
      ev.note_number     = NOTE_W'(note);
      ev.velocity        = VEL_W'(vel);
      ev.sample_position = POS_W'(pos);
      return ev;
   endfunction

   // Mostly note on/off aimed at the current pad notes, with some noise.
   function automatic req_payload_type random_event();
      req_payload_type ev;
      int unsigned     pick;
      pick = $urandom_range(0, 19);
      ev.message_kind = (pick < 2) ? KIND_W'($urandom) :
                        (pick < 8) ? KIND_NOTE_OFF : KIND_NOTE_ON;
      ev.note_number  = ($urandom_range(0, 19) < 17) ? note_pool[$urandom_range(0, 2)]
                                                     : NOTE_W'($urandom);
      ev.channel      = ($urandom_range(0, 9) < 8) ? CHAN_W'($urandom_range(1, 16))
                                                   : CHAN_W'($urandom);
      pick = $urandom_range(0, 19);
      ev.velocity     = (pick < 2) ? VEL_W'(0) : (pick < 4) ? VEL_W'(127) :
                        (pick == 4) ? VEL_W'(1) : VEL_W'($urandom);
      ev.sample_position = POS_W'($urandom);
      return ev;
   endfunction

   task automatic send_event(input req_payload_type ev);
      int unsigned gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Wait for every routed event, then give no-match events time to leave the pipe.
   task automatic settle();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Pack the pad map into the seven registers; unused upper bits carry noise.
   task automatic load_map();
      logic [CSR_DATA_W-1:0] notes_lo;
      logic [CSR_DATA_W-1:0] notes_hi;
      logic [CSR_DATA_W-1:0] chans_lo;
      logic [CSR_DATA_W-1:0] chans_hi;
      logic [CSR_DATA_W-1:0] curves;
      logic [CSR_DATA_W-1:0] codes_lo;
      logic [CSR_DATA_W-1:0] codes_hi;
      chans_lo = CSR_DATA_W'({$urandom, $urandom});
      chans_hi = CSR_DATA_W'({$urandom, $urandom});
      curves   = CSR_DATA_W'({$urandom, $urandom});
      for (int p = 0; p < 8; p++) begin
         notes_lo[p * NOTE_W +: NOTE_W] = map_note[p];
         notes_hi[p * NOTE_W +: NOTE_W] = map_note[p + 8];
         chans_lo[p * CHAN_W +: CHAN_W] = map_chan[p];
         chans_hi[p * CHAN_W +: CHAN_W] = map_chan[p + 8];
         codes_lo[p * VEL_W +: VEL_W]   = map_code[p];
         codes_hi[p * VEL_W +: VEL_W]   = map_code[p + 8];
      end
      for (int p = 0; p < PAD_SLOTS; p++) curves[p * CURVE_W +: CURVE_W] = map_curve[p];
      write_reg(REG_NOTES_LOW, notes_lo);
      write_reg(REG_NOTES_HIGH, notes_hi);
      write_reg(REG_CHANS_LOW, chans_lo);
      write_reg(REG_CHANS_HIGH, chans_hi);
      write_reg(REG_CURVES, curves);
      write_reg(REG_CODES_LOW, codes_lo);
      write_reg(REG_CODES_HIGH, codes_hi);
   endtask

   task automatic fill_uniform(input int note, input int chan, input logic [CURVE_W-1:0] curve,
                               input int code);
      for (int p = 0; p < PAD_SLOTS; p++) begin
         map_note[p]  = NOTE_W'(note);
         map_chan[p]  = CHAN_W'(chan);
         map_curve[p] = curve;
         map_code[p]  = VEL_W'(code);
      end
      for (int i = 0; i < 3; i++) note_pool[i] = NOTE_W'(note);
   endtask

   // Pads share a few notes so most events fan out to several pads.
   task automatic randomize_map();
      int unsigned pick;
      for (int i = 0; i < 3; i++) note_pool[i] = NOTE_W'($urandom);
      for (int p = 0; p < PAD_SLOTS; p++) begin
         map_note[p] = ($urandom_range(0, 9) == 0) ? NOTE_W'($urandom)
                                                   : note_pool[$urandom_range(0, 2)];
         pick = $urandom_range(0, 19);
         map_chan[p]  = (pick < 10) ? CHAN_W'(0) :
                        (pick < 17) ? CHAN_W'($urandom_range(1, 16))
                                    : CHAN_W'($urandom_range(17, 31));
         map_curve[p] = CURVE_W'($urandom);
         map_code[p]  = VEL_W'($urandom);
      end
   endtask

   initial begin : stimulus
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      quiet       = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // default drum map, any channel, linear curves
      send_event(make_event(KIND_NOTE_ON, 1, 36, 127, 0));
      send_event(make_event(KIND_NOTE_ON, 16, 48, 1, 'hFFFF));
      send_event(make_event(KIND_NOTE_ON, 3, 38, 0, 'h1234));
      send_event(make_event(KIND_NOTE_OFF, 0, 57, 127, 'h8000));
      send_event(make_event(KIND_NOTE_OFF, 31, 57, 0, 'h7FFF));
      send_event(make_event(KIND_OTHER, 1, 36, 100, 5));
      send_event(make_event(KIND_SPARE, 1, 36, 100, 6));
      send_event(make_event(KIND_NOTE_ON, 1, 60, 64, 7));
      end_burst();
      settle();

      // every pad on one note: fan-out across many pads, all curve codes, saturating filters
      map_chan = '{0, 1, 16, 17, 31, 0, 5, 16, 0, 2, 31, 0, 16, 1, 0, 0};
      for (int p = 0; p < PAD_SLOTS; p++) begin
         map_note[p]  = NOTE_W'(127);
         map_curve[p] = CURVE_W'(p % 8);
         map_code[p]  = VEL_W'(p * 9);
      end
      map_code[4]  = VEL_W'(0);
      map_code[12] = VEL_W'(127);
      load_map();
      write_reg(REG_SPARE, CSR_DATA_W'({$urandom, $urandom}));
      send_event(make_event(KIND_NOTE_ON, 1, 127, 127, 'h0001));
      send_event(make_event(KIND_NOTE_ON, 16, 127, 1, 'h0002));
      send_event(make_event(KIND_NOTE_ON, 2, 127, 64, 'h0004));
      send_event(make_event(KIND_NOTE_ON, 5, 127, 100, 'h0008));
      send_event(make_event(KIND_NOTE_OFF, 16, 127, 90, 'h0010));
      send_event(make_event(KIND_NOTE_ON, 0, 127, 33, 'h0020));
      send_event(make_event(KIND_NOTE_ON, 31, 127, 127, 'h0040));
      send_event(make_event(KIND_NOTE_ON, 17, 127, 10, 'h0080));
      send_event(make_event(KIND_NOTE_ON, 16, 126, 50, 'h0100));
      send_event(make_event(KIND_NOTE_ON, 1, 127, 0, 'h0200));
      end_burst();
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0) fill_uniform(0, 0, CURVE_LINEAR, 0);
         else if (phase == 1) fill_uniform(127, 31, CURVE_SPARE, 127);
         else randomize_map();
         load_map();
         quiet = (phase == 7);
         repeat ((phase < 2) ? 12 : 32) send_event(random_event());
         end_burst();
         settle();
      end

      if (mismatch_count == 0) begin
         $display("[midi_pad_router_velocity_curve] OK");
      end else begin
         $display("[midi_pad_router_velocity_curve] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("[midi_pad_router_velocity_curve] ERROR");
      $finish;
   end

endmodule
